// File: rtl/core/euler_trs_and_normal_matrix_unit_assert.svh
// Assertion macros; clocked on clk, disabled while arst_n is low.
`ifndef EULER_TRS_AND_NORMAL_MATRIX_UNIT_ASSERT_SVH
`define EULER_TRS_AND_NORMAL_MATRIX_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ETNM_CHECK(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("etnm check failed");
`define ETNM_NEVER(lbl, cond) `ETNM_CHECK(lbl, !(cond))
`else
`define ETNM_CHECK(lbl, prop)
`define ETNM_NEVER(lbl, cond)
`endif
`endif

// File: rtl/core/etnm_pkg.sv
package etnm_pkg;

	localparam int unsigned TRIG_W = 18;
	localparam int unsigned ROT_W  = 34;
	localparam int unsigned PROD_W = 54;

	localparam logic [16:0] COEF_A = 17'd102944;
	localparam logic [15:0] COEF_B = 16'd42048;
	localparam logic [12:0] COEF_C = 13'd4640;

	localparam logic [31:0] FIX_ONE = 32'h0001_0000;
	localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_NEG = 32'h8000_0000;

	typedef logic signed [ROT_W-1:0] rot_t;
	typedef logic signed [15:0] scale_t;
	typedef logic signed [31:0] trans_t;

	// rot index is column * 3 + row
	typedef struct packed {
		rot_t [8:0]   rot;
		scale_t [2:0] scale;
		trans_t [2:0] trans;
	} entry_t;

	typedef struct packed {
		logic             which;
		logic [1:0]       col;
		logic [3:0][31:0] elem;
		logic             ovf;
		logic             last;
	} out_t;

endpackage

// File: rtl/core/etnm_front.sv
module etnm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [15:0]         angle_x,
	input  logic [15:0]         angle_y,
	input  logic [15:0]         angle_z,
	input  logic signed [15:0]  scale_x,
	input  logic signed [15:0]  scale_y,
	input  logic signed [15:0]  scale_z,
	input  logic signed [31:0]  trans_x,
	input  logic signed [31:0]  trans_y,
	input  logic signed [31:0]  trans_z,
	output logic                q_push,
	input  logic                q_full,
	output etnm_pkg::entry_t    q_data
);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_TRIG = 4'b0010,
		F_ROT  = 4'b0100,
		F_PUSH = 4'b1000
	} fstate_t;

	localparam logic [2:0] T_SX = 3'd0;
	localparam logic [2:0] T_CX = 3'd1;
	localparam logic [2:0] T_SY = 3'd2;
	localparam logic [2:0] T_CY = 3'd3;
	localparam logic [2:0] T_SZ = 3'd4;
	localparam logic [2:0] T_CZ = 3'd5;

	localparam logic [3:0] P_C1C3   = 4'd0;
	localparam logic [3:0] P_C2S3   = 4'd1;
	localparam logic [3:0] P_C3S1   = 4'd2;
	localparam logic [3:0] P_C1S3   = 4'd3;
	localparam logic [3:0] P_C2C3   = 4'd4;
	localparam logic [3:0] P_S1S3   = 4'd5;
	localparam logic [3:0] P_C2S1   = 4'd6;
	localparam logic [3:0] P_C1C2   = 4'd7;
	localparam logic [3:0] P_S1S2   = 4'd8;
	localparam logic [3:0] P_S1S2S3 = 4'd9;
	localparam logic [3:0] P_C1S2S3 = 4'd10;
	localparam logic [3:0] P_C3S1S2 = 4'd11;
	localparam logic [3:0] P_C1C3S2 = 4'd12;

	localparam logic [1:0] PH_SQ = 2'd0;
	localparam logic [1:0] PH_C  = 2'd1;
	localparam logic [1:0] PH_A  = 2'd2;
	localparam logic [1:0] PH_X  = 2'd3;

	fstate_t state_q;

	logic        in_valid_q;
	logic [15:0] in_ang_q [3];
	etnm_pkg::scale_t in_sc_q [3];
	etnm_pkg::trans_t in_tr_q [3];

	logic [15:0] ang_q [3];
	etnm_pkg::scale_t sc_q [3];
	etnm_pkg::trans_t tr_q [3];

	logic [2:0]  k_q;
	logic [1:0]  ph_q;
	logic [3:0]  m_q;
	logic [16:0] x2_q;
	logic [16:0] t_q;
	logic signed [etnm_pkg::TRIG_W-1:0] trig_q [6];
	logic signed [etnm_pkg::PROD_W-1:0] prod_q [13];

	logic        accept;
	logic        start;
	logic [15:0] a_eff;
	logic [1:0]  quad;
	logic [14:0] um;
	logic [16:0] x;
	logic signed [35:0] a_op;
	logic signed [17:0] b_op;
	logic signed [etnm_pkg::PROD_W-1:0] p;
	logic [16:0] p_sh;
	logic signed [17:0] s18;
	logic signed [etnm_pkg::PROD_W-1:0] q48 [9];

	assign full   = in_valid_q;
	assign accept = push && !in_valid_q;
	assign start  = (state_q == F_IDLE) && in_valid_q;
	assign q_push = (state_q == F_PUSH) && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_q <= 1'b0;
		end else if (accept) begin
			in_valid_q <= 1'b1;
		end else if (start) begin
			in_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_ang_q[0] <= angle_x;
			in_ang_q[1] <= angle_y;
			in_ang_q[2] <= angle_z;
			in_sc_q[0]  <= scale_x;
			in_sc_q[1]  <= scale_y;
			in_sc_q[2]  <= scale_z;
			in_tr_q[0]  <= trans_x;
			in_tr_q[1]  <= trans_y;
			in_tr_q[2]  <= trans_z;
		end
	end

	always_comb begin
		a_eff = k_q[0] ? ang_q[k_q[2:1]] + 16'd16384 : ang_q[k_q[2:1]];
		quad  = a_eff[15:14];
		um    = quad[0] ? 15'd16384 - {1'b0, a_eff[13:0]} : {1'b0, a_eff[13:0]};
		x     = {um, 2'b00};
	end

	always_comb begin
		a_op = '0;
		b_op = '0;
		if (state_q == F_TRIG) begin
			case (ph_q)
				PH_SQ: begin
					a_op = {19'd0, x};
					b_op = {1'b0, x};
				end
				PH_C: begin
					a_op = {19'd0, x2_q};
					b_op = {5'd0, etnm_pkg::COEF_C};
				end
				PH_A: begin
					a_op = {19'd0, x2_q};
					b_op = {1'b0, t_q};
				end
				default: begin
					a_op = {19'd0, x};
					b_op = {1'b0, t_q};
				end
			endcase
		end else begin
			case (m_q)
				P_C1C3: begin
					a_op = 36'(trig_q[T_CY]);
					b_op = trig_q[T_CZ];
				end
				P_C2S3: begin
					a_op = 36'(trig_q[T_CX]);
					b_op = trig_q[T_SZ];
				end
				P_C3S1: begin
					a_op = 36'(trig_q[T_CZ]);
					b_op = trig_q[T_SY];
				end
				P_C1S3: begin
					a_op = 36'(trig_q[T_CY]);
					b_op = trig_q[T_SZ];
				end
				P_C2C3: begin
					a_op = 36'(trig_q[T_CX]);
					b_op = trig_q[T_CZ];
				end
				P_S1S3: begin
					a_op = 36'(trig_q[T_SY]);
					b_op = trig_q[T_SZ];
				end
				P_C2S1: begin
					a_op = 36'(trig_q[T_CX]);
					b_op = trig_q[T_SY];
				end
				P_C1C2: begin
					a_op = 36'(trig_q[T_CY]);
					b_op = trig_q[T_CX];
				end
				P_S1S2: begin
					a_op = 36'(trig_q[T_SY]);
					b_op = trig_q[T_SX];
				end
				P_S1S2S3: begin
					a_op = signed'(prod_q[P_S1S2][35:0]);
					b_op = trig_q[T_SZ];
				end
				P_C1S2S3: begin
					a_op = signed'(prod_q[P_C1S3][35:0]);
					b_op = trig_q[T_SX];
				end
				P_C3S1S2: begin
					a_op = signed'(prod_q[P_C3S1][35:0]);
					b_op = trig_q[T_SX];
				end
				default: begin
					a_op = signed'(prod_q[P_C1C3][35:0]);
					b_op = trig_q[T_SX];
				end
			endcase
		end
	end

	assign p    = a_op * b_op;
	assign p_sh = p[32:16];
	assign s18  = signed'({1'b0, p_sh});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			k_q     <= '0;
			ph_q    <= '0;
			m_q     <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (start) begin
						state_q <= F_TRIG;
						k_q     <= '0;
						ph_q    <= PH_SQ;
					end
				end
				F_TRIG: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == PH_X) begin
						k_q <= k_q + 3'd1;
						if (k_q == T_CZ) begin
							state_q <= F_ROT;
							m_q     <= '0;
						end
					end
				end
				F_ROT: begin
					m_q <= m_q + 4'd1;
					if (m_q == P_C1C3S2) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ang_q <= in_ang_q;
			sc_q  <= in_sc_q;
			tr_q  <= in_tr_q;
		end
		if (state_q == F_TRIG) begin
			case (ph_q)
				PH_SQ:   x2_q <= p_sh;
				PH_C:    t_q  <= {1'b0, etnm_pkg::COEF_B} - p_sh;
				PH_A:    t_q  <= etnm_pkg::COEF_A - p_sh;
				default: trig_q[k_q] <= quad[1] ? -s18 : s18;
			endcase
		end
		if (state_q == F_ROT) begin
			prod_q[m_q] <= p;
		end
	end

	function automatic etnm_pkg::rot_t rnd18(input logic signed [etnm_pkg::PROD_W-1:0] v);
		logic [etnm_pkg::PROD_W-1:0] mag;
		logic [etnm_pkg::PROD_W-1:0] m;
		logic signed [etnm_pkg::ROT_W-1:0] r;
		mag = v[etnm_pkg::PROD_W-1] ? unsigned'(-v) : unsigned'(v);
		m   = (mag + 54'd131072) >> 18;
		r   = signed'(m[etnm_pkg::ROT_W-1:0]);
		return v[etnm_pkg::PROD_W-1] ? -r : r;
	endfunction

	always_comb begin
		q48[0] = (prod_q[P_C1C3] <<< 16) + prod_q[P_S1S2S3];
		q48[1] = prod_q[P_C2S3] <<< 16;
		q48[2] = prod_q[P_C1S2S3] - (prod_q[P_C3S1] <<< 16);
		q48[3] = prod_q[P_C3S1S2] - (prod_q[P_C1S3] <<< 16);
		q48[4] = prod_q[P_C2C3] <<< 16;
		q48[5] = prod_q[P_C1C3S2] + (prod_q[P_S1S3] <<< 16);
		q48[6] = prod_q[P_C2S1] <<< 16;
		q48[7] = -(54'(trig_q[T_SX]) <<< 32);
		q48[8] = prod_q[P_C1C2] <<< 16;
		for (int i = 0; i < 9; i++) begin
			q_data.rot[i] = rnd18(q48[i]);
		end
		for (int j = 0; j < 3; j++) begin
			q_data.scale[j] = sc_q[j];
			q_data.trans[j] = tr_q[j];
		end
	end

endmodule

// File: rtl/core/etnm_fifo.sv
module etnm_fifo #(
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  etnm_pkg::entry_t data_in,
	input  logic             pop,
	output logic             empty,
	output etnm_pkg::entry_t data_out
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	etnm_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign data_out = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] ptr);
		return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= nxt(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= nxt(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= data_in;
		end
	end

endmodule

// File: rtl/core/etnm_back.sv
module etnm_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	output logic             q_pop,
	input  etnm_pkg::entry_t q_data,
	input  logic             pop,
	output logic             empty,
	output etnm_pkg::out_t   res
);

	typedef enum logic [6:0] {
		B_IDLE = 7'b0000001,
		B_MUL  = 7'b0000010,
		B_MOUT = 7'b0000100,
		B_TOUT = 7'b0001000,
		B_DSET = 7'b0010000,
		B_DIV  = 7'b0100000,
		B_NOUT = 7'b1000000
	} bstate_t;

	localparam logic [1:0] LAST_COL  = 2'd2;
	localparam logic [1:0] TRANS_COL = 2'd3;
	localparam logic [3:0] DIV_LAST  = 4'd13;

	bstate_t state_q;
	etnm_pkg::entry_t ent_q;
	logic [1:0]  col_q;
	logic [3:0]  cnt_q;
	logic signed [49:0] prod_q [3];
	logic [27:0] dq_q [3];
	logic [15:0] rem_q [3];
	logic        neg_q [3];
	logic        rneg_q [3];
	logic        rnz_q [3];
	logic [15:0] dmag_q;
	logic        zero_q;

	logic        ov_q;
	etnm_pkg::out_t od_q;

	logic        slot_free;
	logic        out_load;
	etnm_pkg::rot_t r_lane [3];
	etnm_pkg::scale_t sc_sel;
	logic [15:0] smag;
	logic [27:0] dq_n [3];
	logic [15:0] rem_n [3];
	logic [31:0] mel [3];
	logic [31:0] nel [3];

	assign slot_free = !ov_q || pop;
	assign out_load  = slot_free && ((state_q == B_MOUT) || (state_q == B_TOUT) ||
		(state_q == B_NOUT));
	assign q_pop     = (state_q == B_IDLE) && !q_empty;
	assign empty     = !ov_q;
	assign res       = od_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			r_lane[i] = ent_q.rot[4'(col_q) * 4'd3 + 4'(i)];
		end
		sc_sel = ent_q.scale[col_q];
		smag   = sc_sel[15] ? unsigned'(-sc_sel) : unsigned'(sc_sel);
	end

	function automatic logic [31:0] rnd22(input logic signed [49:0] v);
		logic [49:0] mag;
		logic [49:0] m;
		mag = v[49] ? unsigned'(-v) : unsigned'(v);
		m   = (mag + 50'd2097152) >> 22;
		return v[49] ? -m[31:0] : m[31:0];
	endfunction

	always_comb begin
		logic [16:0] trial;
		logic [15:0] r;
		logic [27:0] q;
		for (int i = 0; i < 3; i++) begin
			r = rem_q[i];
			q = dq_q[i];
			for (int b = 0; b < 2; b++) begin
				trial = {r, q[27]};
				q     = {q[26:0], 1'b0};
				if (trial >= {1'b0, dmag_q}) begin
					trial = trial - {1'b0, dmag_q};
					q[0]  = 1'b1;
				end
				r = trial[15:0];
			end
			rem_n[i] = r;
			dq_n[i]  = q;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mel[i] = rnd22(prod_q[i]);
			if (zero_q) begin
				nel[i] = rneg_q[i] ? etnm_pkg::SAT_NEG : (rnz_q[i] ? etnm_pkg::SAT_POS : '0);
			end else begin
				nel[i] = neg_q[i] ? -{4'd0, dq_q[i]} : {4'd0, dq_q[i]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			col_q   <= '0;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (pop) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						state_q <= B_MUL;
						col_q   <= '0;
					end
				end
				B_MUL: state_q <= B_MOUT;
				B_MOUT: begin
					if (slot_free) begin
						if (col_q == LAST_COL) begin
							state_q <= B_TOUT;
						end else begin
							col_q   <= col_q + 2'd1;
							state_q <= B_MUL;
						end
					end
				end
				B_TOUT: begin
					if (slot_free) begin
						col_q   <= '0;
						state_q <= B_DSET;
					end
				end
				B_DSET: begin
					cnt_q   <= '0;
					state_q <= B_DIV;
				end
				B_DIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == DIV_LAST) begin
						state_q <= B_NOUT;
					end
				end
				B_NOUT: begin
					if (slot_free) begin
						if (col_q == LAST_COL) begin
							state_q <= B_IDLE;
						end else begin
							col_q   <= col_q + 2'd1;
							state_q <= B_DSET;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		logic [33:0] rmag;
		logic [33:0] num;
		if (q_pop) begin
			ent_q <= q_data;
		end
		if (state_q == B_MUL) begin
			for (int i = 0; i < 3; i++) begin
				prod_q[i] <= r_lane[i] * sc_sel;
			end
		end
		if (state_q == B_DSET) begin
			dmag_q <= smag;
			zero_q <= (sc_sel == '0);
			for (int i = 0; i < 3; i++) begin
				rmag = r_lane[i][33] ? unsigned'(-r_lane[i]) : unsigned'(r_lane[i]);
				num  = rmag + {13'd0, smag, 5'd0};
				dq_q[i]   <= num[33:6];
				rem_q[i]  <= '0;
				neg_q[i]  <= r_lane[i][33] ^ sc_sel[15];
				rneg_q[i] <= r_lane[i][33];
				rnz_q[i]  <= (r_lane[i] != '0);
			end
		end
		if (state_q == B_DIV) begin
			dq_q  <= dq_n;
			rem_q <= rem_n;
		end
		if (state_q == B_MOUT && slot_free) begin
			od_q.which   <= 1'b0;
			od_q.col     <= col_q;
			od_q.elem[0] <= mel[0];
			od_q.elem[1] <= mel[1];
			od_q.elem[2] <= mel[2];
			od_q.elem[3] <= '0;
			od_q.ovf     <= 1'b0;
			od_q.last    <= 1'b0;
		end
		if (state_q == B_TOUT && slot_free) begin
			od_q.which   <= 1'b0;
			od_q.col     <= TRANS_COL;
			od_q.elem[0] <= ent_q.trans[0];
			od_q.elem[1] <= ent_q.trans[1];
			od_q.elem[2] <= ent_q.trans[2];
			od_q.elem[3] <= etnm_pkg::FIX_ONE;
			od_q.ovf     <= 1'b0;
			od_q.last    <= 1'b0;
		end
		if (state_q == B_NOUT && slot_free) begin
			od_q.which   <= 1'b1;
			od_q.col     <= col_q;
			od_q.elem[0] <= nel[0];
			od_q.elem[1] <= nel[1];
			od_q.elem[2] <= nel[2];
			od_q.elem[3] <= '0;
			od_q.ovf     <= zero_q;
			od_q.last    <= (col_q == LAST_COL);
		end
	end

endmodule

// File: rtl/core/euler_trs_and_normal_matrix_unit.sv
// Builds, for each input word of Euler angles (y, then x, then z), scales and a translation,
// seven result words: the four columns of the model matrix T*R*S, then the three columns of
// the normal matrix R*inverse(S), the last flagged by last_column. The front part takes a
// word into a one-word input register and evaluates six sines and cosines and the rotation
// with a single shared multiplier; a short queue then feeds the back part, which forms the
// model columns with three row multipliers and the normal columns with three row dividers
// retiring two quotient bits a cycle. The back part sets the sustained rate, with the front
// part working on the next word meanwhile. A zero scale saturates its normal column and
// raises overflow.
`include "euler_trs_and_normal_matrix_unit_assert.svh"

module euler_trs_and_normal_matrix_unit #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [15:0]        angle_x,
	input  logic [15:0]        angle_y,
	input  logic [15:0]        angle_z,
	input  logic signed [15:0] scale_x,
	input  logic signed [15:0] scale_y,
	input  logic signed [15:0] scale_z,
	input  logic signed [31:0] trans_x,
	input  logic signed [31:0] trans_y,
	input  logic signed [31:0] trans_z,
	output logic               empty,
	input  logic               pop,
	output logic               which_matrix,
	output logic [1:0]         column_index,
	output logic signed [31:0] elem_row0,
	output logic signed [31:0] elem_row1,
	output logic signed [31:0] elem_row2,
	output logic signed [31:0] elem_row3,
	output logic               overflow,
	output logic               last_column
);

	logic             q_push;
	logic             q_full;
	logic             q_pop;
	logic             q_empty;
	etnm_pkg::entry_t q_wdata;
	etnm_pkg::entry_t q_rdata;
	etnm_pkg::out_t   res;

	etnm_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.angle_x (angle_x),
		.angle_y (angle_y),
		.angle_z (angle_z),
		.scale_x (scale_x),
		.scale_y (scale_y),
		.scale_z (scale_z),
		.trans_x (trans_x),
		.trans_y (trans_y),
		.trans_z (trans_z),
		.q_push  (q_push),
		.q_full  (q_full),
		.q_data  (q_wdata)
	);

	etnm_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.full     (q_full),
		.data_in  (q_wdata),
		.pop      (q_pop),
		.empty    (q_empty),
		.data_out (q_rdata)
	);

	etnm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.q_data  (q_rdata),
		.pop     (pop),
		.empty   (empty),
		.res     (res)
	);

	assign which_matrix = res.which;
	assign column_index = res.col;
	assign elem_row0    = signed'(res.elem[0]);
	assign elem_row1    = signed'(res.elem[1]);
	assign elem_row2    = signed'(res.elem[2]);
	assign elem_row3    = signed'(res.elem[3]);
	assign overflow     = res.ovf;
	assign last_column  = res.last;

	`ETNM_NEVER(a_queue_overrun, q_push && q_full)
	`ETNM_NEVER(a_queue_underrun, q_pop && q_empty)
	`ETNM_CHECK(a_last_on_final, (!empty && last_column) |-> (which_matrix && column_index == 2'd2))
	`ETNM_CHECK(a_model_no_ovf, (!empty && !which_matrix) |-> !overflow)
	`ETNM_CHECK(a_normal_row3, (!empty && which_matrix) |-> (elem_row3 == 32'sd0))

endmodule

// File: tb/sv/euler_trs_and_normal_matrix_checker.sv
`timescale 1ns / 100ps

module euler_trs_and_normal_matrix_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic [15:0]        angle_x,
	input  logic [15:0]        angle_y,
	input  logic [15:0]        angle_z,
	input  logic signed [15:0] scale_x,
	input  logic signed [15:0] scale_y,
	input  logic signed [15:0] scale_z,
	input  logic signed [31:0] trans_x,
	input  logic signed [31:0] trans_y,
	input  logic signed [31:0] trans_z,
	input  logic               empty,
	input  logic               pop,
	input  logic               which_matrix,
	input  logic [1:0]         column_index,
	input  logic signed [31:0] elem_row0,
	input  logic signed [31:0] elem_row1,
	input  logic signed [31:0] elem_row2,
	input  logic signed [31:0] elem_row3,
	input  logic               overflow,
	input  logic               last_column,
	output int                 errors,
	output int                 pending
);

	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;

	etnm_pkg::out_t column_q[$];

	assign pending = column_q.size();

	function automatic longint abs64(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint round_away(longint v, int k);
		longint m;
		m = (abs64(v) + (64'sd1 <<< (k - 1))) >>> k;
		return (v < 0) ? -m : m;
	endfunction

	function automatic longint quarter_sine(longint u);
		longint x, x2, t;
		x  = u * 4;
		x2 = (x * x) >>> 16;
		t  = 42048 - ((x2 * 4640) >>> 16);
		t  = 102944 - ((x2 * t) >>> 16);
		return (x * t) >>> 16;
	endfunction

	function automatic longint sine(logic [15:0] a);
		logic [1:0] q;
		longint u, s;
		q = a[15:14];
		u = longint'(a[13:0]);
		s = quarter_sine(q[0] ? 16384 - u : u);
		return q[1] ? -s : s;
	endfunction

	function automatic longint cosine(logic [15:0] a);
		return sine(a + 16'd16384);
	endfunction

	function automatic logic [31:0] clip(longint v, inout logic sat);
		if (v > SAT_HI) begin
			sat = 1'b1;
			v = SAT_HI;
		end
		if (v < SAT_LO) begin
			sat = 1'b1;
			v = SAT_LO;
		end
		return v[31:0];
	endfunction

	function automatic longint normal_term(longint r, longint s, inout logic ovf);
		longint den, q;
		if (s == 0) begin
			ovf = 1'b1;
			if (r > 0) return SAT_HI;
			if (r < 0) return SAT_LO;
			return 0;
		end
		den = abs64(s) * 64;
		q = (abs64(r) + den / 2) / den;
		if (q > 64'sh8000_0000) q = 64'sh8000_0000;
		return ((r < 0) != (s < 0)) ? -q : q;
	endfunction

	task automatic predict_columns();
		longint c1, s1, c2, s2, c3, s3;
		longint sc[3];
		longint q48[3][3];
		longint r[3][3];
		etnm_pkg::out_t w;
		logic sat, ovf;
		c1 = cosine(angle_y); s1 = sine(angle_y);
		c2 = cosine(angle_x); s2 = sine(angle_x);
		c3 = cosine(angle_z); s3 = sine(angle_z);
		sc[0] = scale_x; sc[1] = scale_y; sc[2] = scale_z;
		q48[0][0] = c1 * c3 * 65536 + s1 * s2 * s3;
		q48[0][1] = c2 * s3 * 65536;
		q48[0][2] = c1 * s2 * s3 - c3 * s1 * 65536;
		q48[1][0] = c3 * s1 * s2 - c1 * s3 * 65536;
		q48[1][1] = c2 * c3 * 65536;
		q48[1][2] = c1 * c3 * s2 + s1 * s3 * 65536;
		q48[2][0] = c2 * s1 * 65536;
		q48[2][1] = -s2 * 65536 * 65536;
		q48[2][2] = c1 * c2 * 65536;
		for (int j = 0; j < 3; j++)
			for (int i = 0; i < 3; i++)
				r[j][i] = round_away(q48[j][i], 18);
		for (int j = 0; j < 3; j++) begin
			sat = 1'b0;
			w = '0;
			w.col = j[1:0];
			for (int i = 0; i < 3; i++)
				w.elem[i] = clip(round_away(r[j][i] * sc[j], 22), sat);
			column_q.push_back(w);
		end
		w = '0;
		w.col = 2'd3;
		w.elem[0] = trans_x;
		w.elem[1] = trans_y;
		w.elem[2] = trans_z;
		w.elem[3] = etnm_pkg::FIX_ONE;
		column_q.push_back(w);
		for (int j = 0; j < 3; j++) begin
			ovf = 1'b0;
			sat = 1'b0;
			w = '0;
			w.which = 1'b1;
			w.col = j[1:0];
			for (int i = 0; i < 3; i++)
				w.elem[i] = clip(normal_term(r[j][i], sc[j], ovf), sat);
			w.ovf = ovf | sat;
			w.last = (j == 2);
			column_q.push_back(w);
		end
	endtask

	task automatic compare_column();
		etnm_pkg::out_t e;
		if (column_q.size() == 0) begin
			$error("unexpected result word");
			errors++;
			return;
		end
		e = column_q.pop_front();
		if (which_matrix !== e.which) begin
			$error("which_matrix: expected %0d, got %0d", e.which, which_matrix);
			errors++;
		end
		if (column_index !== e.col) begin
			$error("column_index: expected %0d, got %0d", e.col, column_index);
			errors++;
		end
		if (elem_row0 !== e.elem[0]) begin
			$error("elem_row0: expected %h, got %h", e.elem[0], elem_row0);
			errors++;
		end
		if (elem_row1 !== e.elem[1]) begin
			$error("elem_row1: expected %h, got %h", e.elem[1], elem_row1);
			errors++;
		end
		if (elem_row2 !== e.elem[2]) begin
			$error("elem_row2: expected %h, got %h", e.elem[2], elem_row2);
			errors++;
		end
		if (elem_row3 !== e.elem[3]) begin
			$error("elem_row3: expected %h, got %h", e.elem[3], elem_row3);
			errors++;
		end
		if (overflow !== e.ovf) begin
			$error("overflow: expected %0d, got %0d", e.ovf, overflow);
			errors++;
		end
		if (last_column !== e.last) begin
			$error("last_column: expected %0d, got %0d", e.last, last_column);
			errors++;
		end
	endtask

	initial errors = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) compare_column();
			if (push && !full) predict_columns();
		end
	end

endmodule

// File: tb/sv/tb_euler_trs_and_normal_matrix_unit.sv
`timescale 1ns / 100ps

module tb_euler_trs_and_normal_matrix_unit;

	localparam int NUM_RANDOM = 150;
	localparam int HOLD_CYCLES = 1500;
	localparam int STALL_LIMIT = 6000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic [15:0]        angle_x = '0;
	logic [15:0]        angle_y = '0;
	logic [15:0]        angle_z = '0;
	logic signed [15:0] scale_x = '0;
	logic signed [15:0] scale_y = '0;
	logic signed [15:0] scale_z = '0;
	logic signed [31:0] trans_x = '0;
	logic signed [31:0] trans_y = '0;
	logic signed [31:0] trans_z = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic               which_matrix;
	logic [1:0]         column_index;
	logic signed [31:0] elem_row0;
	logic signed [31:0] elem_row1;
	logic signed [31:0] elem_row2;
	logic signed [31:0] elem_row3;
	logic               overflow;
	logic               last_column;
	int                 errors;
	int                 pending;
	int                 quiet_cycles = 0;
	logic               brisk_send = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	euler_trs_and_normal_matrix_unit u_dut (.*);

	euler_trs_and_normal_matrix_checker u_check (.*);

	task automatic send_word(input logic [15:0] ax, ay, az,
			input logic [15:0] sx, sy, sz, input logic [31:0] tx, ty, tz);
		int gap;
		gap = brisk_send ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		angle_x <= ax; angle_y <= ay; angle_z <= az;
		scale_x <= sx; scale_y <= sy; scale_z <= sz;
		trans_x <= tx; trans_y <= ty; trans_z <= tz;
		push <= 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_angle();
		case ($urandom_range(0, 5))
			0: return 16'(($urandom_range(0, 3) << 14) + $urandom_range(0, 2) - 1);
			1: return 16'($urandom_range(0, 3) << 14);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_scale();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'h8000;
			2: return 16'h7FFF;
			3: return 16'($urandom_range(0, 2048) - 1024);
			default: return 16'($urandom);
		endcase
	endfunction

	// receiver: long hold first, then random waits with brisk stretches of pops without waits
	initial begin : receiver
		int wait_cycles;
		logic brisk;
		brisk = 1'b0;
		@(posedge arst_n);
		repeat (HOLD_CYCLES) @(posedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0) brisk = ~brisk;
			wait_cycles = brisk ? 0 : $urandom_range(0, 11);
			if (wait_cycles > 0) begin
				pop <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_word(16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0100,
			32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_word(16'h4000, 16'h8000, 16'hC000, 16'h7FFF, 16'h8000, 16'h0001,
			32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
		send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
		send_word(16'h2000, 16'h6000, 16'hA000, 16'h0000, 16'h0000, 16'h0000,
			32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678);
		send_word(16'h3FFF, 16'h4001, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
		send_word(16'hC000, 16'h0001, 16'h8001, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			32'hF0F0_F0F0, 32'h0000_FFFF, 32'hFFFF_0000);
		send_word(16'h8000, 16'hC000, 16'h4000, 16'hFF00, 16'h0080, 16'hFFFF,
			32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_word(16'hBFFF, 16'hE000, 16'h1000, 16'h0001, 16'h0001, 16'h0001,
			32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		for (int n = 0; n < NUM_RANDOM; n++) begin
			if ($urandom_range(0, 19) == 0) brisk_send = ~brisk_send;
			send_word(pick_angle(), pick_angle(), pick_angle(),
				pick_scale(), pick_scale(), pick_scale(),
				32'($urandom), 32'($urandom), 32'($urandom));
		end
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/etnm_pkg.sv
rtl/core/etnm_front.sv
rtl/core/etnm_fifo.sv
rtl/core/etnm_back.sv
rtl/core/euler_trs_and_normal_matrix_unit.sv
tb/sv/euler_trs_and_normal_matrix_checker.sv
tb/sv/tb_euler_trs_and_normal_matrix_unit.sv
